[rtl/core/dual_down_counter_timer_core_assert.svh]
// Assertion macros for the dual down-counter timer checker.
// Both macros expect a clock named clk and an active-low reset rst_n in scope.
`ifndef DUAL_DOWN_COUNTER_TIMER_CORE_ASSERT_SVH
`define DUAL_DOWN_COUNTER_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDTMR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer core check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define DDTMR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer core check failed: next-cycle implication");

`endif

[rtl/core/ddtmr_pkg.sv]
// Shared types and constants for the dual down-counter timer core.
// Used by ddtmr_in_reg, ddtmr_timer and the top level in rtl/core; depends on nothing else.
package ddtmr_pkg;

    // Number of timers in the core.
    localparam int NUM_TIMERS = 2;

    // Request type codes.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Register index codes.
    localparam logic [2:0] REG_LOAD    = 3'd0;
    localparam logic [2:0] REG_VALUE   = 3'd1;
    localparam logic [2:0] REG_CONTROL = 3'd2;
    localparam logic [2:0] REG_INTCLR  = 3'd3;
    localparam logic [2:0] REG_RIS     = 3'd4;
    localparam logic [2:0] REG_MIS     = 3'd5;
    localparam logic [2:0] REG_BGLOAD  = 3'd6;

    // Control byte bit positions.
    localparam int CTL_ONESHOT  = 0;
    localparam int CTL_SIZE32   = 1;
    localparam int CTL_PRE_LO   = 2;
    localparam int CTL_PRE_HI   = 3;
    localparam int CTL_IE       = 5;
    localparam int CTL_PERIODIC = 6;
    localparam int CTL_ENABLE   = 7;

    // Prescale codes; any other code divides by 256.
    localparam logic [1:0] PRE_DIV1  = 2'd0;
    localparam logic [1:0] PRE_DIV16 = 2'd1;

    // Reset values.
    localparam logic [7:0]  CTL_RESET   = 8'h20;
    localparam logic [31:0] COUNT_RESET = 32'hFFFF_FFFF;

    // One input word as held in the input register.
    typedef struct packed {
        logic [1:0]  req_type;
        logic        timer_sel;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
    } ddtmr_item_t;

    // Decoded access presented to one timer.
    typedef struct packed {
        logic        rd;
        logic        wr;
        logic        tick;
        logic [2:0]  reg_index;
        logic [31:0] data;
    } ddtmr_acc_t;

    // What one timer reports back for the current access.
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } ddtmr_stat_t;

endpackage

[rtl/core/ddtmr_in_reg.sv]
// Input register of the timer core: holds one accepted word until it is processed.
// Depends on ddtmr_pkg.
module ddtmr_in_reg
    import ddtmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        advance,
    input  ddtmr_item_t item_in,
    output logic        valid,
    output ddtmr_item_t item_out
);

    logic        valid_reg;
    logic        valid_next;
    ddtmr_item_t item_reg;

    // A new word replaces the old one; otherwise the slot empties as it moves on.
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

[rtl/core/ddtmr_timer.sv]
// One down-counting timer: load, value, control, raw flag and prescaler state.
// Depends on ddtmr_pkg.
module ddtmr_timer
    import ddtmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ddtmr_acc_t  acc,
    output ddtmr_stat_t stat
);

    logic [31:0] reload_reg;
    logic [31:0] reload_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [7:0]  ctrl_reg;
    logic [7:0]  ctrl_next;
    logic        raw_reg;
    logic        raw_next;
    logic [7:0]  pre_reg;
    logic [7:0]  pre_next;

    logic [31:0] size_mask;
    logic [7:0]  pre_mask;
    logic [31:0] cur;
    logic [31:0] dec;
    logic [31:0] rel;
    logic        masked_irq;

    // Size mask, prescale mask and the candidate counter values.
    always_comb
    begin
        size_mask = ctrl_reg[CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        case (ctrl_reg[CTL_PRE_HI:CTL_PRE_LO])
            PRE_DIV1:  pre_mask = 8'h00;
            PRE_DIV16: pre_mask = 8'h0F;
            default:   pre_mask = 8'hFF;
        endcase
        cur = count_reg & size_mask;
        dec = (cur - 32'd1) & size_mask;
        rel = reload_reg & size_mask;
    end

    // Next state for a write or a tick.
    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        ctrl_next   = ctrl_reg;
        raw_next    = raw_reg;
        pre_next    = pre_reg;

        if (acc.wr)
        begin
            case (acc.reg_index)
                REG_LOAD:
                begin
                    reload_next = acc.data;
                    count_next  = acc.data & size_mask;
                    pre_next    = 8'd0;
                end
                REG_CONTROL:
                begin
                    ctrl_next = acc.data[7:0];
                end
                REG_INTCLR:
                begin
                    raw_next = 1'b0;
                end
                REG_BGLOAD:
                begin
                    reload_next = acc.data;
                end
                default:
                begin
                    reload_next = reload_reg;
                end
            endcase
        end
        else if (acc.tick && ctrl_reg[CTL_ENABLE])
        begin
            pre_next = pre_reg + 8'd1;
            if ((pre_reg & pre_mask) == pre_mask)
            begin
                // A count: decrement, then hold, reload or wrap at zero.
                if (cur != 32'd0)
                begin
                    count_next = dec;
                    if (dec == 32'd0)
                    begin
                        raw_next = 1'b1;
                    end
                end
                else if (ctrl_reg[CTL_ONESHOT])
                begin
                    count_next = 32'd0;
                end
                else if (ctrl_reg[CTL_PERIODIC])
                begin
                    count_next = rel;
                    if (rel == 32'd0)
                    begin
                        raw_next = 1'b1;
                    end
                end
                else
                begin
                    count_next = size_mask;
                end
            end
        end
    end

    // Register read, taken from the state before this access.
    always_comb
    begin
        masked_irq     = raw_reg & ctrl_reg[CTL_IE];
        stat.read_data = 32'd0;
        if (acc.rd)
        begin
            case (acc.reg_index)
                REG_LOAD, REG_BGLOAD: stat.read_data = reload_reg;
                REG_VALUE:            stat.read_data = count_reg;
                REG_CONTROL:          stat.read_data = {24'd0, ctrl_reg};
                REG_RIS:              stat.read_data = {31'd0, raw_reg};
                REG_MIS:              stat.read_data = {31'd0, masked_irq};
                default:              stat.read_data = 32'd0;
            endcase
        end
        stat.irq = raw_next & ctrl_next[CTL_IE];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= 32'd0;
            count_reg  <= COUNT_RESET;
            ctrl_reg   <= CTL_RESET;
            raw_reg    <= 1'b0;
            pre_reg    <= 8'd0;
        end
        else
        begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            ctrl_reg   <= ctrl_next;
            raw_reg    <= raw_next;
            pre_reg    <= pre_next;
        end
    end

endmodule

[rtl/core/dual_down_counter_timer_core.sv]
// Dual down-counter timer core, top level.
// Depends on ddtmr_pkg, ddtmr_in_reg and ddtmr_timer.
//
// Usage: each input word is a register read, a register write or one tick
// of the timer clock, applied to both timers. Words enter on in_valid /
// in_stall and each produces exactly one result word on out_valid /
// out_stall carrying read_data (zero unless a read) and irq_lines, the
// masked interrupt of each timer after that word.
// The result word passes through the input register, then through the timer
// update into the output register.
// Throughput is one word per cycle while out_stall is low; the timer state is
// updated in the same edge that loads the output register, so consecutive
// words see each other's effects in order.
// When the receiver stalls, the result holds in the output register and
// the input register can still take one more word; in_stall rises only
// while both are full and out_stall is high.
// Reset clears both registers of valid words and returns each timer to
// load 0, value all ones, control 0x20 and no pending interrupt.
module dual_down_counter_timer_core
    import ddtmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        timer_sel,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [1:0]  irq_lines
);

    logic        s1_valid;
    ddtmr_item_t s1_item;
    ddtmr_item_t in_item;
    logic        in_load;
    logic        advance;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] read_data_reg;
    logic [1:0]  irq_reg;
    logic [31:0] rd_mux;
    logic [1:0]  irq_vec;

    ddtmr_acc_t  acc [NUM_TIMERS];
    ddtmr_stat_t stat [NUM_TIMERS];

    // Handshake: the input word moves on whenever the output register is empty or its result is being taken.
    assign advance  = s1_valid && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid && out_valid_reg && out_stall;
    assign in_load  = in_valid && !in_stall;

    assign in_item.req_type   = req_type;
    assign in_item.timer_sel  = timer_sel;
    assign in_item.reg_index  = reg_index;
    assign in_item.write_data = write_data;

    ddtmr_in_reg u_in_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_load),
        .advance  (advance),
        .item_in  (in_item),
        .valid    (s1_valid),
        .item_out (s1_item)
    );

    // Per-timer access decode and timer instances.
    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_timer
        logic hit;
        assign hit = (s1_item.timer_sel == 1'(i));
        assign acc[i].rd        = advance && (s1_item.req_type == REQ_READ) && hit;
        assign acc[i].wr        = advance && (s1_item.req_type == REQ_WRITE) && hit;
        assign acc[i].tick      = advance && (s1_item.req_type == REQ_TICK);
        assign acc[i].reg_index = s1_item.reg_index;
        assign acc[i].data      = s1_item.write_data;

        ddtmr_timer u_timer
        (
            .clk   (clk),
            .rst_n (rst_n),
            .acc   (acc[i]),
            .stat  (stat[i])
        );
    end

    // Gather read data and interrupt lines from the timers.
    always_comb
    begin
        rd_mux  = 32'd0;
        irq_vec = 2'd0;
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            rd_mux     = rd_mux | stat[k].read_data;
            irq_vec[k] = stat[k].irq;
        end
    end

    // Output register valid: set on a new result, cleared when taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            read_data_reg <= rd_mux;
            irq_reg       <= irq_vec;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_lines = irq_reg;

endmodule

[rtl/core/ddtmr_checker.sv]
// Port-level checker for the dual down-counter timer core, bound to the top level.
// Depends on dual_down_counter_timer_core_assert.svh and dual_down_counter_timer_core.
`include "dual_down_counter_timer_core_assert.svh"

module ddtmr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] read_data,
    input logic [1:0]  irq_lines
);

    // A stalled result word stays valid and unchanged.
    `DDTMR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(irq_lines))

    // The input side only stalls under output backpressure.
    `DDTMR_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // A new result follows an accepted word through the input register.
    `DDTMR_ASSERT_NOW(a_latency, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind dual_down_counter_timer_core ddtmr_checker u_ddtmr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .irq_lines (irq_lines)
);

[bench/ddtmr_result_checker.sv]
`timescale 1ns / 100ps
// Checker for the dual down-counter timer core: watches both word channels,
// predicts each result word and compares it against what the core returns.
// Depends on ddtmr_pkg for register codes and control bit positions.
module ddtmr_result_checker
    import ddtmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic        timer_sel,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] read_data,
    input  logic [1:0]  irq_lines,
    output int          fail_count,
    output int          words_in_flight
);

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  irq_lines;
    } timer_word_t;

    // Predicted timer state, one entry per timer.
    logic [31:0] load_reg  [NUM_TIMERS];
    logic [31:0] count_reg [NUM_TIMERS];
    logic [7:0]  ctl_reg   [NUM_TIMERS];
    logic        raw_irq   [NUM_TIMERS];
    logic [7:0]  pre_count [NUM_TIMERS];

    timer_word_t expected_words [$];
    int          errors;

    initial begin
        fail_count = 0;
        words_in_flight = 0;
        errors = 0;
    end

    function automatic logic [31:0] width_mask(int t);
        return ctl_reg[t][CTL_SIZE32] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    endfunction

    function automatic logic [7:0] prescale_mask(int t);
        logic [1:0] code;
        code = ctl_reg[t][CTL_PRE_HI:CTL_PRE_LO];
        if (code == PRE_DIV1)
            return 8'd0;
        if (code == PRE_DIV16)
            return 8'd15;
        return 8'd255;
    endfunction

    // One decrement of the counter, with the action at zero set by the mode.
    function automatic void count_down(int t);
        logic [31:0] m;
        logic [31:0] c;
        m = width_mask(t);
        c = count_reg[t] & m;
        if (c != 0)
        begin
            c = (c - 1) & m;
            if (c == 0)
                raw_irq[t] = 1'b1;
        end
        else if (ctl_reg[t][CTL_ONESHOT])
        begin
            c = 0;
        end
        else if (ctl_reg[t][CTL_PERIODIC])
        begin
            c = load_reg[t] & m;
            if (c == 0)
                raw_irq[t] = 1'b1;
        end
        else
        begin
            c = m;
        end
        count_reg[t] = c;
    endfunction

    // A tick advances the prescaler of an enabled timer and counts when its
    // selected low bits are all ones.
    function automatic void tick_timer(int t);
        logic [7:0] pm;
        if (!ctl_reg[t][CTL_ENABLE])
            return;
        pm = prescale_mask(t);
        if ((pre_count[t] & pm) == pm)
            count_down(t);
        pre_count[t] = pre_count[t] + 8'd1;
    endfunction

    function automatic logic masked_irq(int t);
        return raw_irq[t] & ctl_reg[t][CTL_IE];
    endfunction

    function automatic logic [31:0] read_timer(int t, logic [2:0] idx);
        case (idx)
            REG_LOAD, REG_BGLOAD: return load_reg[t];
            REG_VALUE:            return count_reg[t];
            REG_CONTROL:          return {24'd0, ctl_reg[t]};
            REG_RIS:              return {31'd0, raw_irq[t]};
            REG_MIS:              return {31'd0, masked_irq(t)};
            default:              return 32'd0;
        endcase
    endfunction

    function automatic void write_timer(int t, logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_LOAD:
            begin
                load_reg[t] = data;
                count_reg[t] = data & width_mask(t);
                pre_count[t] = 8'd0;
            end
            REG_CONTROL: ctl_reg[t] = data[7:0];
            REG_INTCLR:  raw_irq[t] = 1'b0;
            REG_BGLOAD:  load_reg[t] = data;
            default:     ;
        endcase
    endfunction

    // Applies one input word to the predicted state and returns its result.
    function automatic timer_word_t predict_timer_word(logic [1:0] req, logic sel,
                                                       logic [2:0] idx, logic [31:0] data);
        timer_word_t w;
        w.read_data = 32'd0;
        w.irq_lines = 2'd0;
        if (req == REQ_READ)
        begin
            if (int'(sel) < NUM_TIMERS)
                w.read_data = read_timer(int'(sel), idx);
        end
        else if (req == REQ_WRITE)
        begin
            if (int'(sel) < NUM_TIMERS)
                write_timer(int'(sel), idx, data);
        end
        else if (req == REQ_TICK)
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
                tick_timer(t);
        end
        for (int t = 0; t < NUM_TIMERS && t < 2; t++)
            w.irq_lines[t] = masked_irq(t);
        return w;
    endfunction

    // Compare accepted results first, then record the word accepted at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        timer_word_t want;
        timer_word_t got;
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TIMERS; t++)
            begin
                load_reg[t] = 32'd0;
                count_reg[t] = COUNT_RESET;
                ctl_reg[t] = CTL_RESET;
                raw_irq[t] = 1'b0;
                pre_count[t] = 8'd0;
            end
            expected_words.delete();
            errors = 0;
            fail_count <= 0;
            words_in_flight <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.read_data = read_data;
                got.irq_lines = irq_lines;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with none expected, got read_data %08h irq_lines %b",
                             $time, got.read_data, got.irq_lines);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.read_data !== want.read_data)
                    begin
                        errors++;
                        $display("%0t: read_data expected %08h, got %08h",
                                 $time, want.read_data, got.read_data);
                    end
                    if (got.irq_lines !== want.irq_lines)
                    begin
                        errors++;
                        $display("%0t: irq_lines expected %b, got %b",
                                 $time, want.irq_lines, got.irq_lines);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_words.push_back(predict_timer_word(req_type, timer_sel,
                                                            reg_index, write_data));
            fail_count <= errors;
            words_in_flight <= expected_words.size();
        end
    end

endmodule

[bench/tb_dual_down_counter_timer_core.sv]
`timescale 1ns / 100ps
// Top of the dual down-counter timer testbench: clock, reset, stimulus and verdict.
// Depends on ddtmr_pkg, dual_down_counter_timer_core and ddtmr_result_checker.
module tb_dual_down_counter_timer_core;
    import ddtmr_pkg::*;

    // Codes outside the defined set, used to exercise the ignored cases.
    localparam logic [1:0] REQ_IDLE  = 2'd3;
    localparam logic [2:0] REG_SPARE = 3'd7;

    localparam int RANDOM_WORDS = 500;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = REQ_READ;
    logic        timer_sel = 1'b0;
    logic [2:0]  reg_index = REG_LOAD;
    logic [31:0] write_data = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic [1:0]  irq_lines;
    int          fail_count;
    int          words_in_flight;

    dual_down_counter_timer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .timer_sel  (timer_sel),
        .reg_index  (reg_index),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .irq_lines  (irq_lines)
    );

    ddtmr_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .timer_sel       (timer_sel),
        .reg_index       (reg_index),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .irq_lines       (irq_lines),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sends one word after a random gap and waits until the core takes it.
    task automatic send_word(input logic [1:0] req, input logic sel,
                             input logic [2:0] idx, input logic [31:0] data);
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            gap = 0;
        else if (pick < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        timer_sel <= sel;
        reg_index <= idx;
        write_data <= data;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Receiver back-pressure: runs without stall, then short or occasionally long stalls.
    initial
    begin
        wait (rst_n);
        forever
        begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            out_stall <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    end

    // Hard limit on the run length.
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int          sent;
        int          pick;
        logic        sel;
        logic [2:0]  idx;
        logic [31:0] data;
        logic [7:0]  ctl;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values, the unused request type and the unused register index.
        send_word(REQ_READ, 1'b0, REG_VALUE, 32'd0);
        send_word(REQ_READ, 1'b1, REG_CONTROL, 32'd0);
        send_word(REQ_IDLE, 1'b1, REG_SPARE, 32'hFFFF_FFFF);
        send_word(REQ_READ, 1'b0, REG_SPARE, 32'd0);

        // Periodic 32-bit count down to zero, interrupt raised, then cleared.
        send_word(REQ_WRITE, 1'b0, REG_LOAD, 32'd3);
        send_word(REQ_WRITE, 1'b0, REG_CONTROL, 32'h0000_00E2);
        repeat (4) send_word(REQ_TICK, 1'b0, REG_LOAD, 32'd0);
        send_word(REQ_READ, 1'b0, REG_MIS, 32'd0);
        send_word(REQ_WRITE, 1'b0, REG_INTCLR, 32'hFFFF_FFFF);
        send_word(REQ_READ, 1'b0, REG_RIS, 32'd0);

        // Oneshot 16-bit: the load is masked and the counter halts at zero.
        send_word(REQ_WRITE, 1'b1, REG_CONTROL, 32'h0000_00A1);
        send_word(REQ_WRITE, 1'b1, REG_LOAD, 32'h0001_0002);
        repeat (3) send_word(REQ_TICK, 1'b1, REG_VALUE, 32'd0);
        send_word(REQ_READ, 1'b1, REG_VALUE, 32'd0);

        // Writes to a read-only register and to the unused index are ignored.
        send_word(REQ_WRITE, 1'b0, REG_VALUE, 32'h0000_1234);
        send_word(REQ_WRITE, 1'b1, REG_SPARE, 32'hFFFF_FFFF);

        // A periodic reload of zero raises the interrupt.
        send_word(REQ_WRITE, 1'b0, REG_LOAD, 32'd0);
        send_word(REQ_TICK, 1'b0, REG_LOAD, 32'd0);
        send_word(REQ_READ, 1'b0, REG_BGLOAD, 32'd0);

        // Free-running 16-bit wraps from zero to all ones.
        send_word(REQ_WRITE, 1'b1, REG_CONTROL, 32'h0000_0080);
        send_word(REQ_TICK, 1'b1, REG_LOAD, 32'd0);
        send_word(REQ_READ, 1'b1, REG_VALUE, 32'd0);

        // Random mix, weighted toward ticks and small loads so counters reach zero.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            // A rare long run of ticks lets the divide-by-256 prescaler count.
            if ($urandom_range(0, 299) == 0)
            begin
                repeat ($urandom_range(16, 280))
                begin
                    send_word(REQ_TICK, 1'($urandom), 3'($urandom), $urandom);
                    sent++;
                end
            end
            sel = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_word(REQ_TICK, sel, 3'($urandom), $urandom);
            end
            else if (pick < 70)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    idx = REG_LOAD;
                else if (pick < 55)
                    idx = REG_CONTROL;
                else if (pick < 70)
                    idx = REG_INTCLR;
                else if (pick < 85)
                    idx = REG_BGLOAD;
                else
                    idx = 3'($urandom_range(0, 7));
                data = $urandom;
                if (idx == REG_LOAD || idx == REG_BGLOAD)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        data = $urandom_range(0, 6);
                    else if (pick < 75)
                        data = ($urandom_range(0, 3) << 16) | $urandom_range(0, 5);
                end
                else if (idx == REG_CONTROL)
                begin
                    ctl = 8'($urandom);
                    if ($urandom_range(0, 4) != 0)
                        ctl[CTL_ENABLE] = 1'b1;
                    if ($urandom_range(0, 9) < 7)
                        ctl[CTL_PRE_HI:CTL_PRE_LO] = PRE_DIV1;
                    data[7:0] = ctl;
                end
                send_word(REQ_WRITE, sel, idx, data);
            end
            else if (pick < 95)
            begin
                send_word(REQ_READ, sel, 3'($urandom_range(0, 7)), $urandom);
            end
            else
            begin
                send_word(REQ_IDLE, sel, 3'($urandom), $urandom);
            end
            sent++;
        end

        // Drain the results still in flight, then give the verdict.
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
